@@ src/lspq_pkg.sv @@
// Package for the linear-scan priority queue: opcodes, status codes,
// sequencer states, compare-unit result type and parameter defaults.
// Used by lspq_cmp and linear_scan_priority_queue_unit.
package lspq_pkg;

  localparam int DEF_CAPACITY      = 64;
  localparam int DEF_VALUE_BITS    = 32;
  localparam int DEF_PRIORITY_BITS = 16;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CHANGE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_PEEK    = 3'd4;

  localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_RAISED    = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } seq_state_t;

  // Result of the shared compare unit for one entry read from the store.
  typedef struct packed {
    logic better;  // entry beats the current best (priority, then value)
    logic match;   // entry value equals the lookup key
    logic raise;   // requested priority is larger than the entry's
  } cmp_res_t;

endpackage

@@ src/lspq_store.sv @@
// Entry store: value and priority arrays with one write port and one
// registered read port. Depends on nothing but its parameters.
module lspq_store #(
  parameter int DEPTH = 64,
  parameter int VW    = 32,
  parameter int PW    = 16,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wval,
  input  logic [PW-1:0] wpri,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [VW-1:0] rval,
  output logic [PW-1:0] rpri
);

  logic [VW-1:0] val_mem [DEPTH];
  logic [PW-1:0] pri_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wval;
      pri_mem[waddr] <= wpri;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rval <= val_mem[raddr];
      rpri <= pri_mem[raddr];
    end
  end

endmodule

@@ src/lspq_cmp.sv @@
// Shared compare unit: ranks one entry against the running best and
// checks it against the lookup key. Depends on lspq_pkg.
module lspq_cmp #(
  parameter int VW = 32,
  parameter int PW = 16
) (
  input  logic [VW-1:0]      ent_val,
  input  logic [PW-1:0]      ent_pri,
  input  logic [VW-1:0]      best_val,
  input  logic [PW-1:0]      best_pri,
  input  logic [VW-1:0]      key_val,
  input  logic [PW-1:0]      key_pri,
  output lspq_pkg::cmp_res_t res
);
  import lspq_pkg::*;

  always_comb begin
    res.better = (ent_pri < best_pri) || ((ent_pri == best_pri) && (ent_val < best_val));
    res.match  = (ent_val == key_val);
    res.raise  = (key_pri > ent_pri);
  end

endmodule

@@ src/linear_scan_priority_queue_unit.sv @@
// Linear-scan min-priority queue: unsorted entry store, one shared compare
// unit and the sequencer that walks the store. Depends on lspq_pkg,
// lspq_store and lspq_cmp.
//
// Usage: an item arrives on in_valid/in_ready with in_opcode, in_item_value
// and in_item_priority; one result leaves on out_valid/out_ready with
// out_status, out_head_value, out_head_priority and out_entry_count.
// The block takes one item at a time; in_ready is high only while idle.
// Enqueue, clear, unused opcodes and requests on an empty queue need no
// walk of the store. Peek and change priority read the store one entry
// per cycle through its single read port (change stops at the first
// matching value). Dequeue scans, then moves the later entries down one
// place per cycle.
// The result sits in an output register; the next item is accepted while
// it waits, and a stalled receiver only holds the following result back.
// Reset empties the queue at once; the store contents are not cleared.
module linear_scan_priority_queue_unit #(
  parameter int CAPACITY      = lspq_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS    = lspq_pkg::DEF_VALUE_BITS,
  parameter int PRIORITY_BITS = lspq_pkg::DEF_PRIORITY_BITS,
  parameter int CW            = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lspq_pkg::OP_BITS-1:0]        in_opcode,
  input  logic [VALUE_BITS-1:0]               in_item_value,
  input  logic [PRIORITY_BITS-1:0]            in_item_priority,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lspq_pkg::STATUS_BITS-1:0]    out_status,
  output logic [VALUE_BITS-1:0]               out_head_value,
  output logic [PRIORITY_BITS-1:0]            out_head_priority,
  output logic [CW-1:0]                       out_entry_count
);
  import lspq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  seq_state_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic [OP_BITS-1:0]       op_r, op_nxt;
  logic [VALUE_BITS-1:0]    key_val_r, key_val_nxt;
  logic [PRIORITY_BITS-1:0] key_pri_r, key_pri_nxt;
  logic [CW-1:0]            issue_r, issue_nxt;
  logic                     pend_r, pend_nxt;
  logic [CW-1:0]            pend_idx_r, pend_idx_nxt;
  logic [VALUE_BITS-1:0]    best_val_r, best_val_nxt;
  logic [PRIORITY_BITS-1:0] best_pri_r, best_pri_nxt;
  logic [CW-1:0]            best_idx_r, best_idx_nxt;
  logic [STATUS_BITS-1:0]   res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0]    res_val_r, res_val_nxt;
  logic [PRIORITY_BITS-1:0] res_pri_r, res_pri_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0]    out_val_r, out_val_nxt;
  logic [PRIORITY_BITS-1:0] out_pri_r, out_pri_nxt;
  logic [CW-1:0]            out_cnt_r, out_cnt_nxt;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0]    mem_wval, mem_rval;
  logic [PRIORITY_BITS-1:0] mem_wpri, mem_rpri;

  cmp_res_t                 cmp;
  logic                     take;
  logic [VALUE_BITS-1:0]    cur_val;
  logic [PRIORITY_BITS-1:0] cur_pri;
  logic [CW-1:0]            cur_idx;
  logic [CW-1:0]            last_idx;
  logic                     in_acc;

  lspq_store #(
    .DEPTH(CAPACITY),
    .VW   (VALUE_BITS),
    .PW   (PRIORITY_BITS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wval (mem_wval),
    .wpri (mem_wpri),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rval (mem_rval),
    .rpri (mem_rpri)
  );

  lspq_cmp #(
    .VW(VALUE_BITS),
    .PW(PRIORITY_BITS)
  ) u_cmp (
    .ent_val (mem_rval),
    .ent_pri (mem_rpri),
    .best_val(best_val_r),
    .best_pri(best_pri_r),
    .key_val (key_val_r),
    .key_pri (key_pri_r),
    .res     (cmp)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign in_acc            = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_value    = out_val_r;
  assign out_head_priority = out_pri_r;
  assign out_entry_count   = out_cnt_r;

  assign last_idx = count_r - CW'(1);

  // The first entry returned seeds the running best.
  assign take    = (pend_idx_r == '0) || cmp.better;
  assign cur_val = take ? mem_rval : best_val_r;
  assign cur_pri = take ? mem_rpri : best_pri_r;
  assign cur_idx = take ? pend_idx_r : best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_val_r    <= key_val_nxt;
    key_pri_r    <= key_pri_nxt;
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    best_val_r   <= best_val_nxt;
    best_pri_r   <= best_pri_nxt;
    best_idx_r   <= best_idx_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_pri_r    <= res_pri_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_pri_r    <= out_pri_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    key_val_nxt    = key_val_r;
    key_pri_nxt    = key_pri_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    best_val_nxt   = best_val_r;
    best_pri_nxt   = best_pri_r;
    best_idx_nxt   = best_idx_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_pri_nxt    = res_pri_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_pri_nxt    = out_pri_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wval       = in_item_value;
    mem_wpri       = in_item_priority;
    mem_re         = 1'b0;
    mem_raddr      = issue_r[AW-1:0];

    // Walking phases issue one read per cycle until the last entry.
    if ((state_r == S_SCAN) || (state_r == S_SHIFT)) begin
      if (issue_r < count_r) begin
        mem_re       = 1'b1;
        issue_nxt    = issue_r + CW'(1);
        pend_nxt     = 1'b1;
        pend_idx_nxt = issue_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_opcode;
          key_val_nxt    = in_item_value;
          key_pri_nxt    = in_item_priority;
          res_status_nxt = STAT_OK;
          res_val_nxt    = '0;
          res_pri_nxt    = '0;
          issue_nxt      = '0;
          state_nxt      = S_DONE;
          case (in_opcode)
            OP_ENQUEUE: begin
              if (count_r == CAP_C) begin
                res_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_CHANGE: begin
              res_status_nxt = STAT_NOT_FOUND;
              if (count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (pend_r) begin
          if (op_r == OP_CHANGE) begin
            if (cmp.match) begin
              if (cmp.raise) begin
                res_status_nxt = STAT_RAISED;
              end else begin
                res_status_nxt = STAT_OK;
                mem_we         = 1'b1;
                mem_waddr      = pend_idx_r[AW-1:0];
                mem_wval       = mem_rval;
                mem_wpri       = key_pri_r;
              end
              pend_nxt  = 1'b0;
              state_nxt = S_DONE;
            end else if (pend_idx_r == last_idx) begin
              pend_nxt  = 1'b0;
              state_nxt = S_DONE;
            end
          end else begin
            best_val_nxt = cur_val;
            best_pri_nxt = cur_pri;
            best_idx_nxt = cur_idx;
            if (pend_idx_r == last_idx) begin
              res_val_nxt = cur_val;
              res_pri_nxt = cur_pri;
              pend_nxt    = 1'b0;
              if (op_r == OP_DEQUEUE) begin
                if (cur_idx == last_idx) begin
                  count_nxt = last_idx;
                  state_nxt = S_DONE;
                end else begin
                  issue_nxt = cur_idx + CW'(1);
                  state_nxt = S_SHIFT;
                end
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
        end
      end

      S_SHIFT: begin
        // Each entry read at index i lands one place lower.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r[AW-1:0] - AW'(1);
          mem_wval  = mem_rval;
          mem_wpri  = mem_rpri;
          if (pend_idx_r == last_idx) begin
            count_nxt = last_idx;
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          out_pri_nxt    = res_pri_r;
          out_cnt_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
